### hw/rtl/css_pkg.sv
// Shared constants, types and item layout for the closest segment search block.
package css_pkg;

   localparam int MAX_SEGMENTS = 1024;
   localparam int COORD_BITS   = 16;
   localparam int T_BITS       = 16;
   localparam int INDEX_BITS   = $clog2(MAX_SEGMENTS);
   localparam int COUNT_BITS   = $clog2(MAX_SEGMENTS + 2);
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int MUL_BITS     = COORD_BITS + 2;
   localparam int PROD_BITS    = 2 * MUL_BITS;
   localparam int DOT_BITS     = 2 * COORD_BITS + 3;
   localparam int LEN_BITS     = 2 * COORD_BITS + 2;
   localparam int DIST_BITS    = 2 * COORD_BITS + 1;
   localparam int STEP_BITS    = $clog2(T_BITS);
   localparam int QUEUE_DEPTH  = 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // One segment as it travels from the front end to the projection engine.
   typedef struct packed {
      coord_type             query_x;
      coord_type             query_y;
      coord_type             start_x;
      coord_type             start_y;
      coord_type             end_x;
      coord_type             end_y;
      logic [INDEX_BITS-1:0] index;
      logic                  first;
      logic                  skip;
      logic                  last;
      logic                  overflow;
   } css_entry_type;

endpackage

### hw/rtl/css_if.sv
// Valid/ready channel interfaces for segment items and search results.
interface css_req_if import css_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type query_x;
   coord_type query_y;
   coord_type seg_start_x;
   coord_type seg_start_y;
   coord_type seg_end_x;
   coord_type seg_end_y;
   logic      last_segment;

   modport source (output valid, query_x, query_y, seg_start_x, seg_start_y,
                   seg_end_x, seg_end_y, last_segment, input ready);
   modport sink (input valid, query_x, query_y, seg_start_x, seg_start_y,
                 seg_end_x, seg_end_y, last_segment, output ready);
endinterface

interface css_rsp_if import css_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] nearest_index;
   coord_type             nearest_x;
   coord_type             nearest_y;
   logic                  count_overflow;

   modport source (output valid, nearest_index, nearest_x, nearest_y, count_overflow,
                   input ready);
   modport sink (input valid, nearest_index, nearest_x, nearest_y, count_overflow,
                 output ready);
endinterface

### hw/rtl/css_front.sv
// Front end: accepts segment items, tracks the open set and tags each item.
module css_front import css_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   css_req_if.sink       req,
   input  logic          queue_full,
   output logic          push,
   output css_entry_type entry
);

   logic                  set_open_ff;
   logic [COUNT_BITS-1:0] count_ff;
   coord_type             held_x_ff;
   coord_type             held_y_ff;

   logic                  first;
   logic [COUNT_BITS-1:0] count_cur;
   logic [COUNT_BITS-1:0] count_in;

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   always_comb begin
      first     = !set_open_ff;
      count_cur = first ? '0 : count_ff;
      count_in  = (count_cur <= COUNT_BITS'(MAX_SEGMENTS)) ? count_cur + 1'b1 : count_cur;

      entry.query_x  = first ? req.query_x : held_x_ff;
      entry.query_y  = first ? req.query_y : held_y_ff;
      entry.start_x  = req.seg_start_x;
      entry.start_y  = req.seg_start_y;
      entry.end_x    = req.seg_end_x;
      entry.end_y    = req.seg_end_y;
      entry.index    = count_cur[INDEX_BITS-1:0];
      entry.first    = first;
      entry.skip     = count_cur >= COUNT_BITS'(MAX_SEGMENTS);
      entry.last     = req.last_segment;
      entry.overflow = count_in > COUNT_BITS'(MAX_SEGMENTS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_open_ff <= 1'b0;
         count_ff    <= '0;
      end else if (push) begin
         if (req.last_segment) begin
            set_open_ff <= 1'b0;
            count_ff    <= '0;
         end else begin
            set_open_ff <= 1'b1;
            count_ff    <= count_in;
         end
         held_x_ff <= entry.query_x;
         held_y_ff <= entry.query_y;
      end
   end

   a_set_closes: assert property (@(posedge clock) disable iff (reset)
      (push && req.last_segment) |=> (!set_open_ff && count_ff == '0))
      else $error("set still open after its last item");

endmodule

### hw/rtl/css_queue.sv
// Short queue that decouples the front end from the projection engine.
module css_queue import css_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  css_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output css_entry_type head,
   output logic          empty
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   css_entry_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [CNT_BITS-1:0]   count_ff;

   assign full  = count_ff == CNT_BITS'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push && !full) begin
            slot_ff[wr_ptr_ff] <= push_entry;
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop && !empty) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         unique case ({push && !full, pop && !empty})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("queue fill count beyond its depth");

endmodule

### hw/rtl/css_back.sv
// Projection engine: shared multiplier, bit-serial divider and best-so-far tracking.
module css_back import css_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  css_entry_type head,
   input  logic          empty,
   output logic          pop,
   css_rsp_if.source     rsp
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOT,
      ST_CLASSIFY,
      ST_DIVIDE,
      ST_LERP,
      ST_DIST,
      ST_UPDATE
   } state_type;

   state_type                    state_ff;
   logic [STEP_BITS-1:0]         step_ff;
   css_entry_type                cur_ff;
   logic signed [DIFF_BITS-1:0]  abx_ff, aby_ff, apx_ff, apy_ff;
   logic signed [DOT_BITS-1:0]   dot_ff;
   logic [LEN_BITS-1:0]          len2_ff;
   logic [LEN_BITS-1:0]          rem_ff;
   logic [T_BITS-1:0]            quo_ff;
   coord_type                    px_ff, py_ff;
   logic [DIST_BITS-1:0]         dist_ff;
   logic [DIST_BITS-1:0]         best_dist_ff;
   logic [INDEX_BITS-1:0]        best_index_ff;
   coord_type                    best_x_ff, best_y_ff;
   logic                         rsp_valid_ff;
   logic [INDEX_BITS-1:0]        rsp_index_ff;
   coord_type                    rsp_x_ff, rsp_y_ff;
   logic                         rsp_ovf_ff;

   logic signed [MUL_BITS-1:0]   mul_a, mul_b;
   logic signed [PROD_BITS-1:0]  mul_p;
   logic [PROD_BITS-1:0]         rounded;
   logic signed [DIFF_BITS-1:0]  dx, dy;
   logic [LEN_BITS:0]            div_shift, div_diff;
   logic                         take;
   logic                         out_blocked;
   logic [INDEX_BITS-1:0]        best_index_in;
   coord_type                    best_x_in, best_y_in;
   logic [DIST_BITS-1:0]         best_dist_in;

   assign pop = (state_ff == ST_IDLE) && !empty;

   assign dx = {px_ff[COORD_BITS-1], px_ff} - {cur_ff.query_x[COORD_BITS-1], cur_ff.query_x};
   assign dy = {py_ff[COORD_BITS-1], py_ff} - {cur_ff.query_y[COORD_BITS-1], cur_ff.query_y};

   // One signed multiplier, its operands picked by state and step.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_DOT: begin
            unique case (step_ff[1:0])
               2'd0: begin
                  mul_a = {abx_ff[DIFF_BITS-1], abx_ff};
                  mul_b = {apx_ff[DIFF_BITS-1], apx_ff};
               end
               2'd1: begin
                  mul_a = {aby_ff[DIFF_BITS-1], aby_ff};
                  mul_b = {apy_ff[DIFF_BITS-1], apy_ff};
               end
               2'd2: begin
                  mul_a = {abx_ff[DIFF_BITS-1], abx_ff};
                  mul_b = {abx_ff[DIFF_BITS-1], abx_ff};
               end
               default: begin
                  mul_a = {aby_ff[DIFF_BITS-1], aby_ff};
                  mul_b = {aby_ff[DIFF_BITS-1], aby_ff};
               end
            endcase
         end
         ST_LERP: begin
            mul_a = {(MUL_BITS-T_BITS)'(0), quo_ff};
            mul_b = step_ff[0] ? {aby_ff[DIFF_BITS-1], aby_ff} : {abx_ff[DIFF_BITS-1], abx_ff};
         end
         ST_DIST: begin
            mul_a = step_ff[0] ? {dy[DIFF_BITS-1], dy} : {dx[DIFF_BITS-1], dx};
            mul_b = mul_a;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      rounded   = mul_p + (PROD_BITS'(1) << (T_BITS - 1));
      div_shift = {rem_ff, 1'b0};
      div_diff  = div_shift - {1'b0, len2_ff};

      take          = !cur_ff.skip && (cur_ff.first || dist_ff < best_dist_ff);
      best_dist_in  = take ? dist_ff : best_dist_ff;
      best_index_in = take ? cur_ff.index : best_index_ff;
      best_x_in     = take ? px_ff : best_x_ff;
      best_y_in     = take ? py_ff : best_y_ff;
      out_blocked   = rsp_valid_ff && !rsp.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         best_dist_ff  <= '1;
         best_index_ff <= '0;
         best_x_ff     <= '0;
         best_y_ff     <= '0;
      end else begin
         // A new result may replace one that drains at the same edge.
         if (state_ff == ST_UPDATE && cur_ff.last && !out_blocked) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!empty) begin
                  cur_ff  <= head;
                  abx_ff  <= {head.end_x[COORD_BITS-1], head.end_x}
                           - {head.start_x[COORD_BITS-1], head.start_x};
                  aby_ff  <= {head.end_y[COORD_BITS-1], head.end_y}
                           - {head.start_y[COORD_BITS-1], head.start_y};
                  apx_ff  <= {head.query_x[COORD_BITS-1], head.query_x}
                           - {head.start_x[COORD_BITS-1], head.start_x};
                  apy_ff  <= {head.query_y[COORD_BITS-1], head.query_y}
                           - {head.start_y[COORD_BITS-1], head.start_y};
                  step_ff <= '0;
                  state_ff <= head.skip ? ST_UPDATE : ST_DOT;
               end
            end
            ST_DOT: begin
               unique case (step_ff[1:0])
                  2'd0:    dot_ff  <= $signed(mul_p[DOT_BITS-1:0]);
                  2'd1:    dot_ff  <= dot_ff + $signed(mul_p[DOT_BITS-1:0]);
                  2'd2:    len2_ff <= mul_p[LEN_BITS-1:0];
                  default: len2_ff <= len2_ff + mul_p[LEN_BITS-1:0];
               endcase
               if (step_ff[1:0] == 2'd3) begin
                  step_ff  <= '0;
                  state_ff <= ST_CLASSIFY;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_CLASSIFY: begin
               // Degenerate segment or query behind the start: clamp to start.
               priority if (len2_ff == '0 || dot_ff[DOT_BITS-1] || dot_ff == '0) begin
                  px_ff    <= cur_ff.start_x;
                  py_ff    <= cur_ff.start_y;
                  state_ff <= ST_DIST;
               end else if (dot_ff[LEN_BITS-1:0] >= len2_ff) begin
                  px_ff    <= cur_ff.end_x;
                  py_ff    <= cur_ff.end_y;
                  state_ff <= ST_DIST;
               end else begin
                  rem_ff   <= dot_ff[LEN_BITS-1:0];
                  quo_ff   <= '0;
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               // Restoring division, one quotient bit per cycle.
               if (!div_diff[LEN_BITS]) begin
                  rem_ff <= div_diff[LEN_BITS-1:0];
               end else begin
                  rem_ff <= div_shift[LEN_BITS-1:0];
               end
               quo_ff <= {quo_ff[T_BITS-2:0], !div_diff[LEN_BITS]};
               if (step_ff == STEP_BITS'(T_BITS - 1)) begin
                  step_ff  <= '0;
                  state_ff <= ST_LERP;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_LERP: begin
               if (step_ff[0]) begin
                  py_ff    <= cur_ff.start_y + rounded[T_BITS+COORD_BITS-1:T_BITS];
                  step_ff  <= '0;
                  state_ff <= ST_DIST;
               end else begin
                  px_ff   <= cur_ff.start_x + rounded[T_BITS+COORD_BITS-1:T_BITS];
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_DIST: begin
               if (step_ff[0]) begin
                  dist_ff  <= dist_ff + mul_p[DIST_BITS-1:0];
                  step_ff  <= '0;
                  state_ff <= ST_UPDATE;
               end else begin
                  dist_ff <= mul_p[DIST_BITS-1:0];
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_UPDATE: begin
               if (cur_ff.last) begin
                  if (!out_blocked) begin
                     rsp_index_ff  <= best_index_in;
                     rsp_x_ff      <= best_x_in;
                     rsp_y_ff      <= best_y_in;
                     rsp_ovf_ff    <= cur_ff.overflow;
                     best_dist_ff  <= '1;
                     best_index_ff <= '0;
                     best_x_ff     <= '0;
                     best_y_ff     <= '0;
                     state_ff      <= ST_IDLE;
                  end
               end else begin
                  best_dist_ff  <= best_dist_in;
                  best_index_ff <= best_index_in;
                  best_x_ff     <= best_x_in;
                  best_y_ff     <= best_y_in;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.nearest_index  = rsp_index_ff;
   assign rsp.nearest_x      = rsp_x_ff;
   assign rsp.nearest_y      = rsp_y_ff;
   assign rsp.count_overflow = rsp_ovf_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < len2_ff))
      else $error("divider remainder not below the squared length");

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE && cur_ff.last))
      else $error("result raised without a closing item");

endmodule

### hw/rtl/closest_segment_search.sv
// Nearest-point search over a stream of line segments, one result per set.
// Items run one at a time through the engine's steps on one shared multiplier: load,
// 4 multiply steps, classify, 16 divider steps, 2 interpolation and 2 distance steps,
// update. A clamp to an endpoint skips the divider and interpolation, an ignored item
// goes from load to update; a closing item waits in update until the output can take it.
// Reset (synchronous, active high) closes any open set and empties the queue.
module closest_segment_search import css_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   css_req_if.sink   req,
   css_rsp_if.source rsp
);

   // The front end holds the query point across a set, counts segments and
   // marks items past the index range so the engine only has to skip them.
   // Its tagged items wait in a two-entry queue, so new segments are taken
   // while the engine is still busy with an earlier one.
   css_entry_type push_entry;
   css_entry_type head;
   logic          push;
   logic          full;
   logic          pop;
   logic          empty;

   css_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (full),
      .push       (push),
      .entry      (push_entry)
   );

   css_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head       (head),
      .empty      (empty)
   );

   // The engine projects each segment, keeps the strictly nearest one so the
   // earlier segment wins a tie, and places the result of a set in an output
   // register, from which it drains independently of later items.
   css_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

### tb/testbench.sv
// Self-checking testbench for the closest segment search block.
module testbench;
   import css_pkg::*;

   // One segment as it crosses the request channel.
   typedef struct {
      coord_type query_x;
      coord_type query_y;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      logic      last;
   } segment_type;

   // One search result as it crosses the response channel.
   typedef struct {
      logic [INDEX_BITS-1:0] segment_index;
      coord_type             x;
      coord_type             y;
      logic                  overflow;
   } nearest_type;

   // The book keeps its own copy of the search state. Each accepted segment
   // updates it, and a closing segment files the nearest point it predicts.
   // Results from the block are checked in order against that list.
   class nearest_point_book;
      logic [DIST_BITS-1:0]  best_dist;
      logic [INDEX_BITS-1:0] best_index;
      coord_type             best_x;
      coord_type             best_y;
      coord_type             query_x;
      coord_type             query_y;
      int                    seg_count;
      bit                    set_open;
      nearest_type           awaited[$];
      int                    mismatches;

      function new();
         mismatches = 0;
         clear_set();
      endfunction

      function void clear_set();
         best_dist  = '1;
         best_index = '0;
         best_x     = '0;
         best_y     = '0;
         seg_count  = 0;
         query_x    = '0;
         query_y    = '0;
         set_open   = 1'b0;
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         mismatches++;
      endtask

      function void note_segment(segment_type s);
         longint sx, sy, ex, ey, qx, qy;
         longint abx, aby, apx, apy, len2, dot, t, px, py, dx, dy;
         logic [63:0] d2;
         bit first;
         nearest_type done;
         first = !set_open;
         // The query point only counts on the opening segment of a set.
         if (first) begin
            query_x   = s.query_x;
            query_y   = s.query_y;
            seg_count = 0;
            set_open  = 1'b1;
         end
         // Segments past the index range are counted but never searched.
         if (seg_count < MAX_SEGMENTS) begin
            sx = s.start_x;
            sy = s.start_y;
            ex = s.end_x;
            ey = s.end_y;
            qx = query_x;
            qy = query_y;
            abx = ex - sx;
            aby = ey - sy;
            apx = qx - sx;
            apy = qy - sy;
            len2 = abx * abx + aby * aby;
            dot = abx * apx + aby * apy;
            if (len2 == 0 || dot <= 0) begin
               // Behind the start, or a zero-length segment: the start point.
               px = sx;
               py = sy;
            end else if (dot >= len2) begin
               px = ex;
               py = ey;
            end else begin
               // Q0.16 parameter, then interpolation rounded half up.
               t  = (dot <<< 16) / len2;
               px = sx + ((t * abx + 32768) >>> 16);
               py = sy + ((t * aby + 32768) >>> 16);
            end
            dx = px - qx;
            dy = py - qy;
            d2 = dx * dx + dy * dy;
            // A strictly smaller distance wins, so the earlier segment keeps a tie.
            if (first || d2[DIST_BITS-1:0] < best_dist) begin
               best_dist  = d2[DIST_BITS-1:0];
               best_index = seg_count[INDEX_BITS-1:0];
               best_x     = coord_type'(px);
               best_y     = coord_type'(py);
            end
         end
         if (seg_count <= MAX_SEGMENTS) begin
            seg_count++;
         end
         if (s.last) begin
            done.segment_index = best_index;
            done.x             = best_x;
            done.y             = best_y;
            done.overflow      = (seg_count > MAX_SEGMENTS);
            awaited.insert(awaited.size(), done);
            clear_set();
         end
      endfunction

      task check_result(nearest_type got);
         nearest_type want;
         if (awaited.size() == 0) begin
            report_mismatch("result arrived while no set was closed");
            return;
         end
         want = awaited[0];
         awaited.delete(0);
         if (got.segment_index !== want.segment_index) begin
            report_mismatch($sformatf("nearest_index expected %0d got %0d",
                                      want.segment_index, got.segment_index));
         end
         if (got.x !== want.x) begin
            report_mismatch($sformatf("nearest_x expected %0d got %0d", want.x, got.x));
         end
         if (got.y !== want.y) begin
            report_mismatch($sformatf("nearest_y expected %0d got %0d", want.y, got.y));
         end
         if (got.overflow !== want.overflow) begin
            report_mismatch($sformatf("count_overflow expected %0d got %0d",
                                      want.overflow, got.overflow));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int   sender_idle_pct;
   int   receiver_stall_pct;

   css_req_if req_ch();
   css_rsp_if rsp_ch();

   nearest_point_book book = new();

   closest_segment_search i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A hard stop in case the block hangs or drops a result.
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   // The receiver decides at every falling edge whether it will take a
   // result at the next rising edge.
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // Both channels are sampled at the rising edge, where the handshakes
   // complete. The input is noted before the result is checked, although
   // the latency of the block keeps the two apart anyway.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            book.note_segment('{query_x: req_ch.query_x, query_y: req_ch.query_y,
                                start_x: req_ch.seg_start_x, start_y: req_ch.seg_start_y,
                                end_x: req_ch.seg_end_x, end_y: req_ch.seg_end_y,
                                last: req_ch.last_segment});
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            book.check_result('{segment_index: rsp_ch.nearest_index, x: rsp_ch.nearest_x,
                                y: rsp_ch.nearest_y, overflow: rsp_ch.count_overflow});
         end
      end
   end

   function automatic segment_type make_segment(int qx, int qy, int sx, int sy,
                                                int ex, int ey, bit last);
      return '{query_x: coord_type'(qx), query_y: coord_type'(qy),
               start_x: coord_type'(sx), start_y: coord_type'(sy),
               end_x: coord_type'(ex), end_y: coord_type'(ey), last: last};
   endfunction

   // Coordinates are mostly full range, with a share of small values near
   // the origin and of the two extremes.
   function automatic coord_type pick_coord();
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         1, 2: return coord_type'(int'($urandom_range(0, 128)) - 64);
         default: return coord_type'($urandom());
      endcase
   endfunction

   function automatic coord_type pick_near(coord_type base);
      return coord_type'(int'(base) + int'($urandom_range(0, 32)) - 16);
   endfunction

   // Presents one segment and returns once it has been taken. The task is
   // entered and left just after a falling edge, so valid stays high between
   // back-to-back segments and is never lowered and raised in one step.
   task automatic drive_segment(segment_type s);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.query_x      <= s.query_x;
      req_ch.query_y      <= s.query_y;
      req_ch.seg_start_x  <= s.start_x;
      req_ch.seg_start_y  <= s.start_y;
      req_ch.seg_end_x    <= s.end_x;
      req_ch.seg_end_y    <= s.end_y;
      req_ch.last_segment <= s.last;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Random sets, mostly short. Within a set, segments repeat the previous
   // one now and then to force ties, collapse to a point, or cluster around
   // the query so that projections fall inside the segment often. The query
   // fields of later segments carry noise, since the block must ignore them.
   task automatic drive_random_sets(int item_goal);
      int          sent;
      int          set_length;
      int          mode;
      coord_type   qx;
      coord_type   qy;
      segment_type seg;
      sent = 0;
      seg  = make_segment(0, 0, 0, 0, 0, 0, 1'b0);
      while (sent < item_goal) begin
         set_length = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                  : $urandom_range(1, 6);
         qx = pick_coord();
         qy = pick_coord();
         for (int i = 0; i < set_length; i++) begin
            mode = $urandom_range(0, 9);
            if (mode == 0 && i > 0) begin
               // Same endpoints as the previous segment.
            end else if (mode == 1) begin
               seg.start_x = pick_coord();
               seg.start_y = pick_coord();
               seg.end_x   = seg.start_x;
               seg.end_y   = seg.start_y;
            end else if (mode <= 4) begin
               seg.start_x = pick_near(qx);
               seg.start_y = pick_near(qy);
               seg.end_x   = pick_near(qx);
               seg.end_y   = pick_near(qy);
            end else begin
               seg.start_x = pick_coord();
               seg.start_y = pick_coord();
               seg.end_x   = pick_coord();
               seg.end_y   = pick_coord();
            end
            seg.query_x = (i == 0) ? qx : pick_coord();
            seg.query_y = (i == 0) ? qy : pick_coord();
            seg.last    = (i == set_length - 1);
            drive_segment(seg);
            sent++;
         end
      end
   endtask

   initial begin
      reset                = 1'b1;
      sender_idle_pct      = 0;
      receiver_stall_pct   = 0;
      req_ch.valid         = 1'b0;
      req_ch.query_x       = '0;
      req_ch.query_y       = '0;
      req_ch.seg_start_x   = '0;
      req_ch.seg_start_y   = '0;
      req_ch.seg_end_x     = '0;
      req_ch.seg_end_y     = '0;
      req_ch.last_segment  = 1'b0;
      rsp_ch.ready         = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A zero-length segment yields its start point.
      drive_segment(make_segment(100, -50, 5, -7, 5, -7, 1'b1));
      // The full diagonal, with the query at the opposite corner.
      drive_segment(make_segment(32767, -32768, -32768, -32768, 32767, 32767, 1'b1));
      // The largest possible distance, on a single point at the far corner.
      drive_segment(make_segment(-32768, -32768, 32767, 32767, 32767, 32767, 1'b1));
      // One set that clamps to the start, clamps to the end with a tie that
      // the first segment keeps, projects inside, ties again, and finally
      // passes through the query. The later query fields must be ignored.
      drive_segment(make_segment(0, 0, 16, 16, 64, 64, 1'b0));
      drive_segment(make_segment(999, 999, -64, -64, -16, -16, 1'b0));
      drive_segment(make_segment(-5, -5, -32, 8, 32, 8, 1'b0));
      drive_segment(make_segment(7, 7, -32, 8, 32, 8, 1'b0));
      drive_segment(make_segment(0, 0, 8, -8, -8, 8, 1'b1));
      // Interpolation that lands exactly on a half, in both directions, then one at a third.
      drive_segment(make_segment(1, 0, 0, 0, 1, 1, 1'b1));
      drive_segment(make_segment(-1, 0, 0, 0, -1, -1, 1'b1));
      drive_segment(make_segment(2, 0, 3, 0, 0, 0, 1'b1));
      // Extremes on every coordinate field.
      drive_segment(make_segment(-32768, 32767, 32767, -32768, -32768, 32767, 1'b1));
      drive_segment(make_segment(32767, 32767, -32768, 32767, 32767, -32768, 1'b1));

      drive_random_sets(140);
      sender_idle_pct = 60;
      drive_random_sets(140);
      sender_idle_pct    = 0;
      receiver_stall_pct = 60;
      drive_random_sets(140);
      sender_idle_pct    = 13;
      receiver_stall_pct = 13;
      drive_random_sets(140);
      req_ch.valid <= 1'b0;

      // Drain the outstanding results, then watch a while for strays.
      while (book.awaited.size() != 0) begin
         @(posedge clock);
      end
      repeat (60) @(posedge clock);
      if (book.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
